// ----- rtl/lfba_pkg.sv -----
// Shared types and constants for the lazy free-list block allocator.
`default_nettype none
package lfba_pkg;

  localparam int unsigned CW  = 11;  // counts, pool size and link values
  localparam int unsigned IW  = 10;  // block index field width
  localparam int unsigned SDW = 16;  // slave tdata width
  localparam int unsigned MDW = 24;  // master tdata width

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_LINK = 1'b1
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic exec;       // item accepted this cycle, execute it
    logic link_load;  // head link read data is back
  } cmd_t;

  // datapath/output queue -> controller
  typedef struct packed {
    logic need_read;  // current item pops and needs the next link
    logic busy;       // a result is parked in the hold register
  } ctl_sts_t;

  typedef struct packed {
    status_e        status;
    logic [IW-1:0]  granted;
    logic [CW-1:0]  free_blocks;
  } res_t;

endpackage : lfba_pkg
`default_nettype wire

// ----- rtl/lfba_ctrl.sv -----
// Controller state machine: item acceptance and the link-fetch step.
`default_nettype none
module lfba_ctrl
  import lfba_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire ctl_sts_t sts_i,
  output cmd_t          cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o && sts_i.need_read) begin
          state_d = S_LINK;
        end
      end
      S_LINK: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o.exec      = 1'b0;
    cmd_o.link_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = !sts_i.busy;
        cmd_o.exec = in_valid_i && !sts_i.busy;
      end
      S_LINK: begin
        cmd_o.link_load = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule : lfba_ctrl
`default_nettype wire

// ----- rtl/lfba_dp.sv -----
// Datapath: pool state registers, link memory and result computation.
`default_nettype none
module lfba_dp
  import lfba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 1024
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [CW-1:0] cfg_wdata_i,
  input  wire req_e          req_i,
  input  wire logic [IW-1:0] idx_i,
  input  wire cmd_t          cmd_i,
  output logic               need_read_o,
  output res_t               res_o,
  output logic [CW-1:0]      free_cnt_o,
  output logic [CW-1:0]      pool_n_o
);

  localparam int unsigned AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

  // effective pool size: zero reads as one, saturate at the memory depth
  function automatic logic [CW-1:0] pool_size(input logic [CW-1:0] v);
    logic [CW-1:0] r;
    if (v == '0) begin
      r = CW'(1);
    end else if (32'(v) > 32'(MAX_BLOCKS)) begin
      r = CW'(MAX_BLOCKS);
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic [CW-1:0] n_q, head_q, free_q, setup_q;
  logic          hv_q;

  logic [CW-1:0] mem [MAX_BLOCKS];
  logic [CW-1:0] rd_q, fwdv_q;
  logic          fwd_q, oob_q;

  logic          is_alloc, has_free, do_setup, idx_bad, pool_full;
  logic [CW-1:0] used, idx_ext, free_dec;
  logic          mem_we, mem_re;
  logic [AW-1:0] waddr, raddr;
  logic [CW-1:0] wdata;

  always_comb begin
    is_alloc  = (req_i == REQ_ALLOC);
    has_free  = (free_q != '0);
    used      = n_q - free_q;
    do_setup  = is_alloc && has_free && (setup_q <= used);
    free_dec  = free_q - CW'(1);
    idx_ext   = CW'(idx_i);
    idx_bad   = (idx_ext >= n_q);
    pool_full = (free_q >= n_q);

    need_read_o = is_alloc && has_free && (free_dec != '0);

    res_o.granted     = '0;
    res_o.status      = ST_OK;
    res_o.free_blocks = free_q;
    if (is_alloc) begin
      if (!has_free) begin
        res_o.status = ST_EMPTY;
      end else begin
        res_o.granted     = head_q[IW-1:0];
        res_o.free_blocks = free_dec;
      end
    end else begin
      if (idx_bad) begin
        res_o.status = ST_RANGE;
      end else if (pool_full) begin
        res_o.status = ST_FULL;
      end else begin
        res_o.free_blocks = free_q + CW'(1);
      end
    end

    mem_we = cmd_i.exec && (is_alloc ? do_setup : (!idx_bad && !pool_full));
    waddr  = is_alloc ? AW'(setup_q) : AW'(idx_ext);
    wdata  = is_alloc ? (setup_q + CW'(1)) : (hv_q ? head_q : n_q);
    mem_re = cmd_i.exec && need_read_o;
    raddr  = AW'(head_q);
  end

  // link memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_q   <= mem[raddr];
      // the setup write may land on the head entry in the same cycle
      fwd_q  <= do_setup && (head_q == setup_q);
      fwdv_q <= setup_q + CW'(1);
      oob_q  <= (32'(head_q) >= 32'(MAX_BLOCKS));
    end
  end

  // pool state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q     <= pool_size(CW'(1024));
      head_q  <= '0;
      hv_q    <= 1'b1;
      free_q  <= pool_size(CW'(1024));
      setup_q <= '0;
    end else if (cfg_we_i) begin
      n_q     <= pool_size(cfg_wdata_i);
      head_q  <= '0;
      hv_q    <= 1'b1;
      free_q  <= pool_size(cfg_wdata_i);
      setup_q <= '0;
    end else if (cmd_i.link_load) begin
      head_q <= oob_q ? '0 : (fwd_q ? fwdv_q : rd_q);
    end else if (cmd_i.exec) begin
      if (is_alloc) begin
        if (has_free) begin
          free_q <= free_dec;
          if (do_setup) begin
            setup_q <= setup_q + CW'(1);
          end
          if (free_dec == '0) begin
            hv_q <= 1'b0;
          end
        end
      end else if (!idx_bad && !pool_full) begin
        head_q <= idx_ext;
        hv_q   <= 1'b1;
        free_q <= free_q + CW'(1);
      end
    end
  end

  assign free_cnt_o = free_q;
  assign pool_n_o   = n_q;

endmodule : lfba_dp
`default_nettype wire

// ----- rtl/lfba_outq.sv -----
// Output register with a one-entry hold stage.
`default_nettype none
module lfba_outq
  import lfba_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic load_i,
  input  wire res_t res_i,
  input  wire logic out_ready_i,
  output logic      out_valid_o,
  output res_t      out_o,
  output logic      busy_o
);

  res_t out_q, hold_q;
  logic out_v_q, pend_q;
  logic slot_free;

  assign slot_free = !out_v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      pend_q  <= 1'b0;
    end else if (slot_free) begin
      out_v_q <= pend_q || load_i;
      pend_q  <= 1'b0;
    end else if (load_i) begin
      pend_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free) begin
      if (pend_q) begin
        out_q <= hold_q;
      end else if (load_i) begin
        out_q <= res_i;
      end
    end else if (load_i) begin
      hold_q <= res_i;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;
  assign busy_o      = pend_q;

endmodule : lfba_outq
`default_nettype wire

// ----- rtl/lazy_free_list_block_allocator.sv -----
// Result: each accepted item is registered in the output register or the hold slot.
// Intake: a free takes no extra step; an allocate adds a link-fetch state (head link
//   read from the link memory, registered read port) while more blocks remain free.
// Stall: intake closes while a second result waits in the hold slot for the sink.
// Reset: async active low; pool size 1024, head 0, all blocks free, none set up.
//   The link memory has no reset; entries are written before they are read.
`default_nettype none
module lazy_free_list_block_allocator
  import lfba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 1024
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  // configuration: pool_blocks
  input  wire logic           cfg_we_i,
  input  wire logic [CW-1:0]  cfg_wdata_i,
  // request items
  input  wire logic           s_axis_tvalid,
  output logic                s_axis_tready,
  input  wire logic [SDW-1:0] s_axis_tdata,   // [9:0] block_index, rest zero
  input  wire logic           s_axis_tuser,   // [0] req_type
  // result items
  output logic                m_axis_tvalid,
  input  wire logic           m_axis_tready,
  output logic [MDW-1:0]      m_axis_tdata,   // [9:0] granted_index, [20:10] free_blocks
  output logic [1:0]          m_axis_tuser    // [1:0] status
);

  cmd_t          cmd;
  ctl_sts_t      sts;
  res_t          res, out_res;
  logic          need_read, busy;
  logic [CW-1:0] free_cnt, pool_n;
  req_e          req;

  assign req = req_e'(s_axis_tuser);

  assign sts.need_read = need_read;
  assign sts.busy      = busy;

  // sequencing: accept, then a link-fetch state for a pop that leaves blocks free
  lfba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // head/count registers, lazy setup of links, link memory
  lfba_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req),
    .idx_i       (s_axis_tdata[IW-1:0]),
    .cmd_i       (cmd),
    .need_read_o (need_read),
    .res_o       (res),
    .free_cnt_o  (free_cnt),
    .pool_n_o    (pool_n)
  );

  // result register plus a hold slot; intake waits on the sink only when both are full
  lfba_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (cmd.exec),
    .res_i       (res),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_o       (out_res),
    .busy_o      (busy)
  );

  assign m_axis_tdata = {(MDW - IW - CW)'(0), out_res.free_blocks, out_res.granted};
  assign m_axis_tuser = out_res.status;

  // free count never exceeds the pool size
  a_free_le_pool : assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_cnt <= pool_n)
    else $error("free count above pool size");

  // a pop that needs a link fetch blocks intake for the following cycle
  a_link_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && need_read) |=> !s_axis_tready)
    else $error("intake open during link fetch");

  // every accepted item shows up in the output register or the hold slot
  a_result_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (m_axis_tvalid || busy))
    else $error("accepted item produced no result");

endmodule : lazy_free_list_block_allocator
`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench for the lazy free-list block allocator: directed and random traffic.
`default_nettype none
module tb
  import lfba_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned POOL_MAX    = 1024;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYC  = 6;    // settle time before a pool write and at the end of the run

  logic           clk_i;
  logic           rst_ni;
  logic           cfg_we_i;
  logic [CW-1:0]  cfg_wdata_i;
  logic           s_axis_tvalid;
  logic           s_axis_tready;
  logic [SDW-1:0] s_axis_tdata;   // [9:0] block_index
  logic           s_axis_tuser;   // [0] req_type
  logic           m_axis_tvalid;
  logic           m_axis_tready = 1'b0;
  logic [MDW-1:0] m_axis_tdata;   // [9:0] granted_index, [20:10] free_blocks
  logic [1:0]     m_axis_tuser;   // [1:0] status

  lazy_free_list_block_allocator u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // idle chances in percent, per cycle
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;
  int unsigned mismatches   = 0;
  int unsigned cycle_cnt    = 0;

  // allocator shadow state
  logic [CW-1:0] pool_cfg;
  int unsigned   next_link [POOL_MAX];
  bit            link_written [POOL_MAX];
  int unsigned   head_blk;
  bit            head_ok;
  int unsigned   free_cnt;
  int unsigned   setup_cnt;
  logic [IW-1:0] live_blocks [$];     // blocks currently handed out
  res_t          pending_results [$];

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);

  function automatic int unsigned pool_size();
    if (pool_cfg == '0) return 1;
    if (pool_cfg > POOL_MAX) return POOL_MAX;
    return pool_cfg;
  endfunction

  function automatic void reset_pool();
    head_blk  = 0;
    head_ok   = 1'b1;
    free_cnt  = pool_size();
    setup_cnt = 0;
    foreach (link_written[i]) link_written[i] = 1'b0;
    live_blocks.delete();
  endfunction

  // True when an allocate now would follow a link that was never written.
  function automatic bit pop_hits_blank();
    int unsigned n;
    n = pool_size();
    if (free_cnt <= 1 || head_blk >= POOL_MAX) return 1'b0;
    if (setup_cnt <= n - free_cnt && setup_cnt == head_blk) return 1'b0;
    return !link_written[head_blk];
  endfunction

  function automatic res_t apply_request(req_e kind, logic [IW-1:0] idx);
    res_t        r;
    int unsigned n;
    n = pool_size();
    r.status  = ST_OK;
    r.granted = '0;
    if (kind == REQ_ALLOC) begin
      if (free_cnt == 0) begin
        r.status = ST_EMPTY;
      end else begin
        // lazy setup: link one more fresh block while setup lags usage
        if (setup_cnt <= n - free_cnt) begin
          next_link[setup_cnt]    = setup_cnt + 1;
          link_written[setup_cnt] = 1'b1;
          setup_cnt++;
        end
        r.granted = head_blk[IW-1:0];
        live_blocks.push_back(head_blk[IW-1:0]);
        free_cnt--;
        if (free_cnt != 0) begin
          head_blk = (head_blk < POOL_MAX) ? next_link[head_blk] : 0;
        end else begin
          head_ok = 1'b0;
        end
      end
    end else if (idx >= n) begin
      r.status = ST_RANGE;
    end else if (free_cnt >= n) begin
      r.status = ST_FULL;
    end else begin
      // pushing onto an empty list stores the end mark n
      next_link[idx]    = head_ok ? head_blk : n;
      link_written[idx] = 1'b1;
      head_blk = idx;
      head_ok  = 1'b1;
      free_cnt++;
      for (int i = 0; i < live_blocks.size(); i++) begin
        if (live_blocks[i] == idx) begin
          live_blocks.delete(i);
          break;
        end
      end
    end
    r.free_blocks = free_cnt[CW-1:0];
    return r;
  endfunction

  function automatic void report(string msg);
    if (mismatches < 10) $display("%0t: %s", $realtime, msg);
    mismatches++;
  endfunction

  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report($sformatf("result item with nothing pending: st=%0d idx=%0d free=%0d",
                         m_axis_tuser, m_axis_tdata[9:0], m_axis_tdata[20:10]));
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.status || m_axis_tdata[9:0] !== want.granted ||
            m_axis_tdata[20:10] !== want.free_blocks || m_axis_tdata[23:21] !== 3'b0)
          report($sformatf("mismatch: exp st=%0d idx=%0d free=%0d got st=%0d idx=%0d free=%0d",
                           want.status, want.granted, want.free_blocks, m_axis_tuser,
                           m_axis_tdata[9:0], m_axis_tdata[20:10]));
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input req_e kind, input logic [IW-1:0] idx);
    if (kind == REQ_ALLOC && pop_hits_blank()) begin
      kind = REQ_FREE;
      idx  = IW'($urandom_range(pool_size() - 1));
    end
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(SDW-IW){1'b0}}, idx};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(apply_request(kind, idx));
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic set_pool_blocks(input logic [CW-1:0] value);
    drain_results();
    repeat (SETTLE_CYC) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    pool_cfg = value;
    reset_pool();
  endtask

  task automatic alloc_block();
    send_request(REQ_ALLOC, IW'($urandom_range(1023)));
  endtask

  task automatic free_block(input logic [IW-1:0] idx);
    send_request(REQ_FREE, idx);
  endtask

  // Mostly alloc/free of live blocks; some bogus and double frees as noise.
  task automatic run_mixed_traffic(input int unsigned count, input int unsigned alloc_pct);
    int unsigned r;
    for (int unsigned k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 6)
        free_block(IW'($urandom_range(1023)));
      else if (r < 10)
        free_block(IW'($urandom_range(pool_size() - 1)));
      else if (live_blocks.size() == 0 || $urandom_range(99) < alloc_pct)
        alloc_block();
      else
        free_block(live_blocks[$urandom_range(live_blocks.size() - 1)]);
    end
  endtask

  // Pool as it comes out of reset: top index, stray free, free into a full pool.
  task automatic test_default_pool();
    alloc_block();
    alloc_block();
    free_block(10'd0);
    free_block(10'd1023);
    alloc_block();
    alloc_block();
    free_block(10'd1);
    free_block(10'd0);
    free_block(10'd5);
  endtask

  // One block: empty pool, out-of-range frees, end mark on an empty list.
  task automatic test_single_block();
    set_pool_blocks(11'd0);
    alloc_block();
    alloc_block();
    free_block(10'd1);
    free_block(10'd1023);
    free_block(10'd0);
    free_block(10'd0);
    alloc_block();
    free_block(10'd0);
  endtask

  // Double free while blocks are in use is pushed again, not caught.
  task automatic test_double_free();
    set_pool_blocks(11'd5);
    repeat (3) alloc_block();
    free_block(10'd2);
    free_block(10'd2);
    alloc_block();
    alloc_block();
    free_block(10'd7);
  endtask

  task automatic test_full_pool_traffic();
    set_pool_blocks(11'd1024);
    run_mixed_traffic(300, 75);
  endtask

  task automatic test_tiny_pool();
    set_pool_blocks(11'd1);
    run_mixed_traffic(60, 50);
  endtask

  // Sender holds off mid-run until every result is back.
  task automatic test_small_pool_with_pause();
    set_pool_blocks(11'd13);
    run_mixed_traffic(100, 55);
    drain_results();
    run_mixed_traffic(100, 55);
  endtask

  // All ones saturates to the full pool.
  task automatic test_saturated_pool();
    set_pool_blocks(11'd2047);
    run_mixed_traffic(250, 60);
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    pool_cfg      = 11'd1024;
    reset_pool();
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    snd_idle_pct = 34;
    rcv_idle_pct = 46;
    test_default_pool();
    test_single_block();
    test_double_free();
    test_full_pool_traffic();

    snd_idle_pct = 46;
    rcv_idle_pct = 34;
    test_tiny_pool();
    test_small_pool_with_pause();

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_saturated_pool();

    drain_results();
    repeat (SETTLE_CYC * 2) @(negedge clk_i);
    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule : tb
`default_nettype wire

// ----- files.f -----
rtl/lfba_pkg.sv
rtl/lfba_ctrl.sv
rtl/lfba_dp.sv
rtl/lfba_outq.sv
rtl/lazy_free_list_block_allocator.sv
verif/tb.sv
